>>> rtl/tsms_pkg.sv
`timescale 1ns / 1ps

package tsms_pkg;

    // Configuration register map
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_INNER_RADIUS = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_OUTER_RADIUS = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FINE_SIZE    = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_COARSE_SIZE  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_RAMP_FACTOR  = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_CENTER_X     = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_CENTER_Y     = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_CENTER_Z     = 3'd7;

    // Coefficient sequencer states
    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_LOAD = 2'd1;
    localparam logic [1:0] SEQ_DIV  = 2'd2;
    localparam logic [1:0] SEQ_DONE = 2'd3;

endpackage

>>> rtl/two_sphere_mesh_size_field.sv
`timescale 1ns / 1ps
// Throughput: one point per cycle unless out_stall or the coefficient sequencer holds
// the input; the distance square roots and the ramp divisions are fully pipelined,
// one root bit or one quotient bit per stage.
// Reset: asynchronous, active low; registers return to their default geometry and the
// coefficient sequencer then runs its load, divide and done states, holding in_stall
// and dropping cfg_ready. Every configuration write reruns that sequence.
module two_sphere_mesh_size_field
    import tsms_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16,
    localparam int SIZE_BITS = COORD_BITS - 1,
    localparam int FAC_BITS  = FRAC_BITS + 4,
    localparam int CFG_BITS  = (COORD_BITS > FAC_BITS) ? COORD_BITS : FAC_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic        [SIZE_BITS-1:0]  element_size,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [REG_IDX_BITS-1:0] cfg_index,
    input  logic        [CFG_BITS-1:0]   cfg_data
);

    // Widths of the datapath
    localparam int ROOT_BITS = COORD_BITS + 1;          // distances and coordinate deltas
    localparam int SUM_BITS  = 2 * ROOT_BITS;           // sum of three squares
    localparam int RW        = ROOT_BITS + 2;           // square root remainder
    localparam int DEN_BITS  = SIZE_BITS + FAC_BITS - FRAC_BITS;  // ramp depth
    localparam int T_BITS    = FRAC_BITS + 1;           // ramp position, 0 .. 1.0
    localparam int PROD_BITS = 2 * SIZE_BITS;           // ratio numerators
    localparam int MUL_BITS  = SIZE_BITS + T_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS + 1);

    localparam logic [SIZE_BITS-1:0] SIZE_MAX   = {SIZE_BITS{1'b1}};
    localparam logic [T_BITS-1:0]    T_ONE      = T_BITS'(64'd1 << FRAC_BITS);
    localparam logic [SIZE_BITS-1:0] INNER_RST  = SIZE_BITS'(64'd1 << FRAC_BITS);
    localparam logic [SIZE_BITS-1:0] OUTER_RST  = SIZE_BITS'(64'd4 << FRAC_BITS);
    localparam logic [SIZE_BITS-1:0] FINE_RST   = SIZE_BITS'((64'd3277 << FRAC_BITS) >> 16);
    localparam logic [SIZE_BITS-1:0] COARSE_RST = SIZE_BITS'((64'd13107 << FRAC_BITS) >> 16);
    localparam logic [FAC_BITS-1:0]  FAC_RST    = FAC_BITS'(64'd1 << (FRAC_BITS - 1));

    // Region flags and ramp saturation flags that travel with a point
    typedef struct packed {
        logic       outside;   // beyond the large sphere
        logic       inner;     // inside the small sphere (boundary included)
        logic [1:0] zero;      // ramp position is 0, per lane
        logic [1:0] one;       // ramp position is 1.0, per lane
    } cls_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [SIZE_BITS-1:0]  inner_radius_reg, outer_radius_reg;
    logic        [SIZE_BITS-1:0]  fine_size_reg, coarse_size_reg;
    logic        [FAC_BITS-1:0]   ramp_factor_reg;
    logic signed [COORD_BITS-1:0] center_x_reg, center_y_reg, center_z_reg;

    logic cfg_write;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_radius_reg <= INNER_RST;
            outer_radius_reg <= OUTER_RST;
            fine_size_reg    <= FINE_RST;
            coarse_size_reg  <= COARSE_RST;
            ramp_factor_reg  <= FAC_RST;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INNER_RADIUS: inner_radius_reg <= cfg_data[SIZE_BITS-1:0];
                REG_OUTER_RADIUS: outer_radius_reg <= cfg_data[SIZE_BITS-1:0];
                REG_FINE_SIZE:    fine_size_reg    <= cfg_data[SIZE_BITS-1:0];
                REG_COARSE_SIZE:  coarse_size_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_RAMP_FACTOR:  ramp_factor_reg  <= cfg_data[FAC_BITS-1:0];
                REG_CENTER_X:     center_x_reg     <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y:     center_y_reg     <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Z:     center_z_reg     <= cfg_data[COORD_BITS-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Coefficient sequencer: ramp depths and the two size ratios.
    // One restoring division bit per cycle on both ratios at once; a zero
    // divisor yields an all-ones quotient, which saturates like any overflow.
    // ------------------------------------------------------------------
    logic [1:0]           seq_state_reg;
    logic [CNT_BITS-1:0]  seq_cnt_reg;
    logic [PROD_BITS-1:0] num_reg [0:1];
    logic [PROD_BITS-1:0] quo_reg [0:1];
    logic [SIZE_BITS-1:0] rem_reg [0:1];
    logic [DEN_BITS-1:0]  d_in_reg, d_out_reg;
    logic [SIZE_BITS-1:0] plateau_size_reg, rim_size_reg;

    logic [SIZE_BITS+FAC_BITS-1:0] dprod_in, dprod_out;
    logic [SIZE_BITS-1:0]          seq_den [0:1];
    logic [SIZE_BITS:0]            seq_rsh [0:1];
    logic                          seq_bit [0:1];
    logic [SIZE_BITS-1:0]          ratio_sat [0:1];

    assign dprod_in  = (SIZE_BITS+FAC_BITS)'(ramp_factor_reg)
                     * (SIZE_BITS+FAC_BITS)'(inner_radius_reg);
    assign dprod_out = (SIZE_BITS+FAC_BITS)'(ramp_factor_reg)
                     * (SIZE_BITS+FAC_BITS)'(outer_radius_reg);
    assign seq_den[0] = outer_radius_reg;   // coarse*a / b
    assign seq_den[1] = inner_radius_reg;   // fine*b / a

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            seq_rsh[l] = {rem_reg[l], num_reg[l][PROD_BITS-1]};
            seq_bit[l] = (seq_rsh[l] >= {1'b0, seq_den[l]});
            ratio_sat[l] = (|quo_reg[l][PROD_BITS-1:SIZE_BITS]) ? SIZE_MAX
                                                               : quo_reg[l][SIZE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_LOAD;
            seq_cnt_reg   <= '0;
        end
        else
        begin
            unique case (seq_state_reg)
                SEQ_IDLE:
                begin
                    if (cfg_write)
                        seq_state_reg <= SEQ_LOAD;
                end
                SEQ_LOAD:
                begin
                    seq_state_reg <= SEQ_DIV;
                    seq_cnt_reg   <= '0;
                end
                SEQ_DIV:
                begin
                    seq_cnt_reg <= seq_cnt_reg + 1'b1;
                    if (seq_cnt_reg == CNT_BITS'(PROD_BITS - 1))
                        seq_state_reg <= SEQ_DONE;
                end
                SEQ_DONE:
                begin
                    seq_state_reg <= SEQ_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (seq_state_reg)
            SEQ_LOAD:
            begin
                num_reg[0] <= PROD_BITS'(coarse_size_reg) * PROD_BITS'(inner_radius_reg);
                num_reg[1] <= PROD_BITS'(fine_size_reg) * PROD_BITS'(outer_radius_reg);
                quo_reg[0] <= '0;
                quo_reg[1] <= '0;
                rem_reg[0] <= '0;
                rem_reg[1] <= '0;
                d_in_reg   <= dprod_in[FRAC_BITS +: DEN_BITS];
                d_out_reg  <= dprod_out[FRAC_BITS +: DEN_BITS];
            end
            SEQ_DIV:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    num_reg[l] <= {num_reg[l][PROD_BITS-2:0], 1'b0};
                    quo_reg[l] <= {quo_reg[l][PROD_BITS-2:0], seq_bit[l]};
                    rem_reg[l] <= seq_bit[l] ? SIZE_BITS'(seq_rsh[l] - {1'b0, seq_den[l]})
                                             : seq_rsh[l][SIZE_BITS-1:0];
                end
            end
            SEQ_DONE:
            begin
                plateau_size_reg <= (ratio_sat[0] > fine_size_reg) ? ratio_sat[0]
                                                                   : fine_size_reg;
                rim_size_reg     <= (ratio_sat[1] < coarse_size_reg) ? ratio_sat[1]
                                                                     : coarse_size_reg;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the output
    // register holds a result that is stalled.
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;
    logic [SIZE_BITS-1:0] size_out_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = (seq_state_reg != SEQ_IDLE) || !adv;
    assign cfg_ready = (seq_state_reg == SEQ_IDLE);
    assign out_valid = out_valid_reg;
    assign element_size = size_out_reg;

    // Stage 1: coordinate deltas, magnitude only (the sign drops out in the square)
    logic [ROOT_BITS-1:0] mag_next [0:5];
    logic [ROOT_BITS-1:0] mag_reg  [0:5];
    logic                 mag_vld_reg;

    function automatic logic [ROOT_BITS-1:0] magnitude(input logic signed [ROOT_BITS-1:0] d);
        magnitude = d[ROOT_BITS-1] ? ROOT_BITS'(-d) : ROOT_BITS'(d);
    endfunction

    always_comb
    begin
        mag_next[0] = magnitude(ROOT_BITS'(point_x) - ROOT_BITS'(center_x_reg));
        mag_next[1] = magnitude(ROOT_BITS'(point_y) - ROOT_BITS'(center_y_reg));
        mag_next[2] = magnitude(ROOT_BITS'(point_z) - ROOT_BITS'(center_z_reg));
        mag_next[3] = magnitude(ROOT_BITS'(point_x));
        mag_next[4] = magnitude(ROOT_BITS'(point_y));
        mag_next[5] = magnitude(ROOT_BITS'(point_z));
    end

    // Stage 2: squares
    logic [SUM_BITS-1:0] sq_reg [0:5];
    logic                sq_vld_reg;

    // Square root: stage 0 holds the sums, stage k has k root bits resolved.
    // Lane 0 is the distance to the small centre, lane 1 to the origin.
    logic [SUM_BITS-1:0]  rv_reg  [0:1][0:ROOT_BITS];
    logic [RW-1:0]        rr_reg  [0:1][0:ROOT_BITS];
    logic [ROOT_BITS-1:0] rq_reg  [0:1][0:ROOT_BITS];
    logic [SUM_BITS-1:0]  rv_next [0:1][1:ROOT_BITS];
    logic [RW-1:0]        rr_next [0:1][1:ROOT_BITS];
    logic [ROOT_BITS-1:0] rq_next [0:1][1:ROOT_BITS];
    logic                 rt_vld_reg [0:ROOT_BITS];

    always_comb
    begin
        logic [RW-1:0] rsh;
        logic [RW-1:0] trial;
        for (int l = 0; l < 2; l++)
        begin
            for (int k = 1; k <= ROOT_BITS; k++)
            begin
                rsh   = {rr_reg[l][k-1][RW-3:0], rv_reg[l][k-1][SUM_BITS-1 -: 2]};
                trial = {rq_reg[l][k-1], 2'b01};
                rv_next[l][k] = {rv_reg[l][k-1][SUM_BITS-3:0], 2'b00};
                if (rsh >= trial)
                begin
                    rr_next[l][k] = rsh - trial;
                    rq_next[l][k] = {rq_reg[l][k-1][ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rr_next[l][k] = rsh;
                    rq_next[l][k] = {rq_reg[l][k-1][ROOT_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // Classification: region and the two ramp numerators.
    // Lane 0 ramps off the small sphere surface (inward or outward),
    // lane 1 ramps in from the large sphere surface.
    logic [ROOT_BITS-1:0] rs, rb, a_ext, b_ext, n_in, n_out;
    logic [DEN_BITS-1:0]  den [0:1];
    logic [DEN_BITS-1:0]  n_ext [0:1];
    cls_t                 cls_next;

    assign rs    = rq_reg[0][ROOT_BITS];
    assign rb    = rq_reg[1][ROOT_BITS];
    assign a_ext = ROOT_BITS'(inner_radius_reg);
    assign b_ext = ROOT_BITS'(outer_radius_reg);
    assign den[0] = d_in_reg;
    assign den[1] = d_out_reg;

    always_comb
    begin
        cls_next.outside = (rb > b_ext);
        cls_next.inner   = (rs <= a_ext);
        n_in     = cls_next.inner ? (a_ext - rs) : (rs - a_ext);
        n_out    = b_ext - rb;
        n_ext[0] = DEN_BITS'(n_in);
        n_ext[1] = DEN_BITS'(n_out);
        for (int l = 0; l < 2; l++)
        begin
            cls_next.zero[l] = (n_ext[l] == '0);
            cls_next.one[l]  = (n_ext[l] >= den[l]);
        end
    end

    // Ramp division: (n << FRAC_BITS) / d with n < d, one quotient bit a stage
    logic [DEN_BITS-1:0]  dr_reg  [0:1][0:FRAC_BITS];
    logic [FRAC_BITS-1:0] dq_reg  [0:1][0:FRAC_BITS];
    logic [DEN_BITS-1:0]  dr_next [0:1][1:FRAC_BITS];
    logic [FRAC_BITS-1:0] dq_next [0:1][1:FRAC_BITS];
    cls_t                 cls_reg [0:FRAC_BITS];
    logic                 dv_vld_reg [0:FRAC_BITS];

    always_comb
    begin
        logic [DEN_BITS:0] dsh;
        logic              qb;
        for (int l = 0; l < 2; l++)
        begin
            for (int k = 1; k <= FRAC_BITS; k++)
            begin
                dsh = {dr_reg[l][k-1], 1'b0};
                qb  = (dsh >= {1'b0, den[l]});
                dr_next[l][k] = qb ? DEN_BITS'(dsh - {1'b0, den[l]}) : dsh[DEN_BITS-1:0];
                dq_next[l][k] = {dq_reg[l][k-1][FRAC_BITS-2:0], qb};
            end
        end
    end

    // Interpolation multiply: |B - A| * t, direction kept for the final add
    logic [SIZE_BITS-1:0] lane_a [0:1];
    logic [SIZE_BITS-1:0] lane_b [0:1];
    logic [T_BITS-1:0]    lane_t [0:1];
    logic                 lane_up [0:1];
    logic [SIZE_BITS-1:0] lane_diff [0:1];
    logic [MUL_BITS-1:0]  prod_reg [0:1];
    logic                 up_reg [0:1];
    cls_t                 mcls_reg;
    logic                 mul_vld_reg;

    assign lane_a[0] = fine_size_reg;
    assign lane_a[1] = rim_size_reg;
    assign lane_b[0] = cls_reg[FRAC_BITS].inner ? plateau_size_reg : coarse_size_reg;
    assign lane_b[1] = coarse_size_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            priority if (cls_reg[FRAC_BITS].zero[l])
                lane_t[l] = '0;
            else if (cls_reg[FRAC_BITS].one[l])
                lane_t[l] = T_ONE;
            else
                lane_t[l] = {1'b0, dq_reg[l][FRAC_BITS]};
            lane_up[l]   = (lane_b[l] >= lane_a[l]);
            lane_diff[l] = lane_up[l] ? (lane_b[l] - lane_a[l]) : (lane_a[l] - lane_b[l]);
        end
    end

    // Final: step from A toward B, then pick by region
    logic [SIZE_BITS-1:0] s_lane [0:1];
    logic [SIZE_BITS-1:0] size_next;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            s_lane[l] = up_reg[l] ? (lane_a[l] + prod_reg[l][FRAC_BITS +: SIZE_BITS])
                                  : (lane_a[l] - prod_reg[l][FRAC_BITS +: SIZE_BITS]);
        end
        priority if (mcls_reg.outside)
            size_next = rim_size_reg;
        else if (mcls_reg.inner)
            size_next = s_lane[0];
        else
            size_next = (s_lane[0] < s_lane[1]) ? s_lane[0] : s_lane[1];
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 6; i++)
            begin
                mag_reg[i] <= mag_next[i];
                sq_reg[i]  <= SUM_BITS'(mag_reg[i]) * SUM_BITS'(mag_reg[i]);
            end
            rv_reg[0][0] <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            rv_reg[1][0] <= sq_reg[3] + sq_reg[4] + sq_reg[5];
            for (int l = 0; l < 2; l++)
            begin
                rr_reg[l][0] <= '0;
                rq_reg[l][0] <= '0;
                for (int k = 1; k <= ROOT_BITS; k++)
                begin
                    rv_reg[l][k] <= rv_next[l][k];
                    rr_reg[l][k] <= rr_next[l][k];
                    rq_reg[l][k] <= rq_next[l][k];
                end
                dr_reg[l][0] <= n_ext[l];
                dq_reg[l][0] <= '0;
                for (int k = 1; k <= FRAC_BITS; k++)
                begin
                    dr_reg[l][k] <= dr_next[l][k];
                    dq_reg[l][k] <= dq_next[l][k];
                end
                prod_reg[l] <= MUL_BITS'(lane_diff[l]) * MUL_BITS'(lane_t[l]);
                up_reg[l]   <= lane_up[l];
            end
            cls_reg[0] <= cls_next;
            for (int k = 1; k <= FRAC_BITS; k++)
                cls_reg[k] <= cls_reg[k-1];
            mcls_reg     <= cls_reg[FRAC_BITS];
            size_out_reg <= size_next;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_vld_reg   <= 1'b0;
            sq_vld_reg    <= 1'b0;
            for (int k = 0; k <= ROOT_BITS; k++)
                rt_vld_reg[k] <= 1'b0;
            for (int k = 0; k <= FRAC_BITS; k++)
                dv_vld_reg[k] <= 1'b0;
            mul_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mag_vld_reg   <= in_valid && !in_stall;
            sq_vld_reg    <= mag_vld_reg;
            rt_vld_reg[0] <= sq_vld_reg;
            for (int k = 1; k <= ROOT_BITS; k++)
                rt_vld_reg[k] <= rt_vld_reg[k-1];
            dv_vld_reg[0] <= rt_vld_reg[ROOT_BITS];
            for (int k = 1; k <= FRAC_BITS; k++)
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            mul_vld_reg   <= dv_vld_reg[FRAC_BITS];
            out_valid_reg <= mul_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cfg_restarts_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (seq_state_reg == SEQ_LOAD))
        else $error("configuration write did not restart the coefficient sequence");

    a_plateau_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_state_reg == SEQ_IDLE) |-> (plateau_size_reg >= fine_size_reg))
        else $error("plateau size below fine_size");

    a_rim_size_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_state_reg == SEQ_IDLE) |-> (rim_size_reg <= coarse_size_reg))
        else $error("rim size above coarse_size");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_state_reg != SEQ_IDLE) |=> !mag_vld_reg || !$past(adv) || $past(!in_valid))
        else $error("point accepted while coefficients were being computed");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench
    import tsms_pkg::*;
;

    localparam int CW   = 24;
    localparam int SW   = 23;
    localparam int FB   = 16;
    localparam int FW   = 20;
    localparam int LAT  = 47;
    localparam int WDOG = 20000;
    localparam logic [63:0] SIZE_MAX = (64'd1 << SW) - 1;
    localparam logic [63:0] ONE_Q    = 64'd1 << FB;

    // Geometry shadow of the block's registers, used by the size predictor.
    typedef struct {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] fine;
        logic [63:0] coarse;
        logic [63:0] fac;
        longint      cx;
        longint      cy;
        longint      cz;
    } geom_t;

    // Expected sizes in order of acceptance; compares results as they leave.
    class size_scoreboard;
        logic [SW-1:0] pending_sizes[$];
        int            errors;

        function void note_point(logic [SW-1:0] sz);
            pending_sizes = {pending_sizes, sz};
        endfunction

        function void check_size(logic [SW-1:0] got);
            logic [SW-1:0] want;
            if (pending_sizes.size() == 0)
            begin
                $display("%0t: unexpected element_size %0d", $time, got);
                errors++;
            end
            else
            begin
                want = pending_sizes.pop_front();
                if (want !== got)
                begin
                    $display("%0t: element_size expected %0d actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic out_valid;
    logic out_stall;
    logic [SW-1:0] element_size;
    logic cfg_valid;
    logic cfg_ready;
    logic [REG_IDX_BITS-1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    geom_t          geom;
    size_scoreboard sizes;
    int             idle_pct;
    int             quiet_cycles;
    bit             allow_out_stall;

    two_sphere_mesh_size_field i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .element_size (element_size),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Bit-serial integer square root, floor.
    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] sq_mag(longint d);
        logic [63:0] u;
        u = (d < 0) ? -d : d;
        return u * u;
    endfunction

    function automatic logic [63:0] quot_sat(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        if (den == 0)
            return SIZE_MAX;
        q = num / den;
        return (q > SIZE_MAX) ? SIZE_MAX : q;
    endfunction

    // Ramp position: zero below, one at or past the depth (covers depth zero).
    function automatic logic [63:0] ramp_pos(longint n, logic [63:0] d);
        if (n <= 0)
            return 0;
        if (n >= d)
            return ONE_Q;
        return (64'(n) << FB) / d;
    endfunction

    function automatic logic [63:0] blend(logic [63:0] lo, logic [63:0] hi, logic [63:0] t);
        if (hi >= lo)
            return lo + (((hi - lo) * t) >> FB);
        return lo - (((lo - hi) * t) >> FB);
    endfunction

    function automatic logic [SW-1:0] predict_size(longint px, longint py, longint pz);
        logic [63:0] rs, rb, q, s_out, b_in, d_in, d_out, res, s1, s2;
        rs = root_floor(sq_mag(px - geom.cx) + sq_mag(py - geom.cy) + sq_mag(pz - geom.cz));
        rb = root_floor(sq_mag(px) + sq_mag(py) + sq_mag(pz));
        q     = quot_sat(geom.coarse * geom.a, geom.b);
        s_out = (q > geom.fine) ? q : geom.fine;
        q     = quot_sat(geom.fine * geom.b, geom.a);
        b_in  = (q < geom.coarse) ? q : geom.coarse;
        d_in  = (geom.fac * geom.a) >> FB;
        d_out = (geom.fac * geom.b) >> FB;
        if (rb > geom.b)
            res = b_in;
        else if (rs <= geom.a)
        begin
            if (geom.a - rs <= d_in)
                res = blend(geom.fine, s_out, ramp_pos(longint'(geom.a - rs), d_in));
            else
                res = s_out;
        end
        else
        begin
            s1  = blend(geom.fine, geom.coarse, ramp_pos(longint'(rs - geom.a), d_in));
            s2  = blend(b_in, geom.coarse, ramp_pos(longint'(geom.b - rb), d_out));
            res = (s1 < s2) ? s1 : s2;
        end
        return (res > SIZE_MAX) ? SIZE_MAX[SW-1:0] : res[SW-1:0];
    endfunction

    // Write one register once the block takes it; mirror it in the shadow.
    task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_INNER_RADIUS: geom.a      = val[SW-1:0];
            REG_OUTER_RADIUS: geom.b      = val[SW-1:0];
            REG_FINE_SIZE:    geom.fine   = val[SW-1:0];
            REG_COARSE_SIZE:  geom.coarse = val[SW-1:0];
            REG_RAMP_FACTOR:  geom.fac    = val[FW-1:0];
            REG_CENTER_X:     geom.cx     = longint'($signed(val));
            REG_CENTER_Y:     geom.cy     = longint'($signed(val));
            REG_CENTER_Z:     geom.cz     = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic load_geometry(logic [SW-1:0] a, logic [SW-1:0] b, logic [SW-1:0] fine,
                                 logic [SW-1:0] coarse, logic [FW-1:0] fac,
                                 logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz);
        write_reg(REG_INNER_RADIUS, CW'(a));
        write_reg(REG_OUTER_RADIUS, CW'(b));
        write_reg(REG_FINE_SIZE, CW'(fine));
        write_reg(REG_COARSE_SIZE, CW'(coarse));
        write_reg(REG_RAMP_FACTOR, CW'(fac));
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        cfg_valid <= 1'b0;
    endtask

    // Send one point; hold it until accepted, then record its expected size.
    task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= x;
        point_y  <= y;
        point_z  <= z;
        do
            @(posedge clk);
        while (in_stall);
        sizes.note_point(predict_size(longint'($signed(x)), longint'($signed(y)),
                                      longint'($signed(z))));
    endtask

    // Wait for the pipeline to drain before touching the registers.
    task automatic drain();
        in_valid <= 1'b0;
        while (sizes.pending_sizes.size() != 0)
            @(posedge clk);
        repeat (LAT + 4)
            @(posedge clk);
    endtask

    // Points near the spheres mostly, with a share of full-range coordinates.
    task automatic random_point();
        logic [CW-1:0] x, y, z;
        int sel;
        sel = $urandom_range(9);
        if (sel < 2)
        begin
            x = CW'($urandom);
            y = CW'($urandom);
            z = CW'($urandom);
        end
        else if (sel < 6)
        begin
            x = CW'(geom.cx + $signed($urandom_range(2 * geom.a + 2)) - longint'(geom.a));
            y = CW'(geom.cy + $signed($urandom_range(2 * geom.a + 2)) - longint'(geom.a));
            z = CW'(geom.cz + $signed($urandom_range(2 * geom.a + 2)) - longint'(geom.a));
        end
        else
        begin
            x = CW'($signed($urandom_range(2 * geom.b + 2)) - longint'(geom.b));
            y = CW'($signed($urandom_range(2 * geom.b + 2)) - longint'(geom.b));
            z = CW'($signed($urandom_range(2 * geom.b + 2)) - longint'(geom.b));
        end
        send_point(x, y, z);
    endtask

    // Draw a random geometry: small sphere inside the large one, mostly.
    task automatic random_geometry();
        logic [SW-1:0] a, b;
        b = SW'($urandom_range(32768, 1048576));
        a = SW'($urandom_range(1, b / 2));
        load_geometry(a, b, SW'($urandom_range(1, 65536)), SW'($urandom_range(1, 262144)),
                      FW'($urandom_range(0, 1048575)),
                      CW'($signed($urandom_range(b / 2)) - longint'(b / 4)),
                      CW'($signed($urandom_range(b / 2)) - longint'(b / 4)),
                      CW'($signed($urandom_range(b / 2)) - longint'(b / 4)));
    endtask

    // Drive output stall independently of everything else.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= allow_out_stall && ($urandom_range(99) < idle_pct);
    end

    // Check every result transaction at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sizes.check_size(element_size);
    end

    // Watchdog: count cycles where no transaction of any kind moves.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        sizes           = new();
        quiet_cycles    = 0;
        idle_pct        = 28;
        allow_out_stall = 1'b1;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        point_x         = '0;
        point_y         = '0;
        point_z         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        geom = '{a: 65536, b: 262144, fine: 3277, coarse: 13107, fac: 32768,
                 cx: 0, cy: 0, cz: 0};
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: centre, boundaries of both spheres, outside, extremes.
        send_point(24'd0, 24'd0, 24'd0);
        send_point(24'd65536, 24'd0, 24'd0);
        send_point(24'd65537, 24'd0, 24'd0);
        send_point(24'd262144, 24'd0, 24'd0);
        send_point(24'd262145, 24'd0, 24'd0);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_point(24'h800000, 24'h800000, 24'h800000);
        send_point(24'h800000, 24'h7FFFFF, 24'd0);
        send_point(24'd0, 24'd131072, 24'hFF0000);
        drain();

        // Zero ramp depth and offset centre: ramps saturate straight to one.
        load_geometry(23'd65536, 23'd262144, 23'd3277, 23'd13107, 20'd0,
                      24'd65536, 24'hFF0000, 24'd0);
        send_point(24'd65536, 24'hFF0000, 24'd0);
        send_point(24'd131072, 24'hFF0000, 24'd0);
        send_point(24'd200000, 24'd0, 24'd0);
        send_point(24'd0, 24'd262144, 24'd0);
        drain();

        // Register extremes: maximum radii, sizes and factor, extreme centres.
        load_geometry(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 20'hFFFFF,
                      24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_point(24'd0, 24'd0, 24'd0);
        send_point(24'h800000, 24'h7FFFFF, 24'h800000);
        drain();

        // Minimum radii and sizes; large ratio saturations.
        load_geometry(23'd1, 23'd1, 23'd1, 23'd1, 20'd1, 24'd0, 24'd0, 24'd0);
        send_point(24'd0, 24'd0, 24'd0);
        send_point(24'd1, 24'd0, 24'd0);
        send_point(24'd2, 24'd0, 24'd0);
        drain();
        load_geometry(23'd1, 23'h7FFFFF, 23'h7FFFFF, 23'd1, 20'hFFFFF,
                      24'd0, 24'd0, 24'd0);
        send_point(24'd100, 24'd0, 24'd0);
        send_point(24'h400000, 24'd0, 24'd0);
        drain();

        // Random phases; the first one runs with no idling on either side.
        for (int ph = 0; ph < 14; ph++)
        begin
            idle_pct        = (ph == 0) ? 0 : 28;
            allow_out_stall = 1'b1;
            random_geometry();
            for (int n = 0; n < 100; n++)
            begin
                random_point();
                // Hold off the sender until every expected size has come back.
                if (n == 50 && ph == 3)
                begin
                    in_valid <= 1'b0;
                    while (sizes.pending_sizes.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (sizes.errors == 0 && sizes.pending_sizes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
